// ===== rtl/wspp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspp_pkg
// Shared types and constants of the wheel speed PID / PWM regulator.
// ----------------------------------------------------------------------------
package wspp_pkg;

  localparam int unsigned SpeedLimit = 7680000;
  localparam int unsigned SpeedMinQ8 = 768;
  localparam int unsigned SpeedJumpQ8 = 5120;
  localparam int unsigned SpeedTinyQ8 = 25;

  typedef enum logic [1:0] {
    FUNC_TARGET = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_SIDE   = 3'd3,
    REG_ENABLE = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARGET,
    ST_SAMPLE,
    ST_SDIV,
    ST_SFIN,
    ST_TICK,
    ST_DDIV,
    ST_P,
    ST_I,
    ST_D,
    ST_TFIN,
    ST_OUT
  } state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic do_target;
    logic do_sample;
    logic sdiv_start;
    logic do_sfin;
    logic ddiv_start;
    logic do_p;
    logic do_i;
    logic do_d;
    logic do_tfin;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic div_done;
    logic tick_active;
  } sts_t;

endpackage

// ===== rtl/wheel_speed_pid_pwm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pid_pwm
// Wheel speed regulator: speed estimate from encoder samples, incremental
// PID and H-bridge pin control.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel carries func (set target, angle
// sample or control tick) and its fields; each request gives exactly one
// result with the PWM value, bridge pins, direction and newest speed.
// Path of a request through the sequencer: an unknown func goes straight
// to the result; a set target takes one update step; a tick that does not
// run the PID (frozen or zero target) only closes the tick; a sample
// runs one 64-step divider run, then shifts the new speed in; a PID tick
// runs one 64-step divider run for the derivative, then three
// multiply-accumulate steps (the speed mean uses a reciprocal multiply).
// One request is in work at a time; the next is taken the cycle after its
// result leaves. Stall on the result holds it and keeps the input stalled.
// Reset clears all control state and loads the gain defaults. Configuration
// writes go through cfg_valid/cfg_ready and are always ready.
// ----------------------------------------------------------------------------
module wheel_speed_pid_pwm #(
  parameter int unsigned HISTORY_DEPTH = 4,
  parameter int unsigned PWM_MAX = 15000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [11:0]        angle_raw_i,
  input  logic [31:0]        time_ms_i,
  input  logic signed [23:0] target_speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        pwm_duty_o,
  output logic               pin_a_o,
  output logic               pin_b_o,
  output logic [1:0]         direction_o,
  output logic [22:0]        measured_speed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import wspp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  wspp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  wspp_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .PWM_MAX       (PWM_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_accept_i      (in_valid_i & ~in_stall_o),
    .angle_raw_i      (angle_raw_i),
    .time_ms_i        (time_ms_i),
    .target_speed_i   (target_speed_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pwm_duty_o       (pwm_duty_o),
    .pin_a_o          (pin_a_o),
    .pin_b_o          (pin_b_o),
    .direction_o      (direction_o),
    .measured_speed_o (measured_speed_o)
  );
endmodule

// ===== rtl/wspp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspp_div
// Restoring divider, one quotient bit per cycle, unsigned 64 by 64 bits.
// ----------------------------------------------------------------------------
module wspp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  // Shift one numerator bit in per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/wspp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspp_ctrl
// Sequencer: steps one request through the datapath and presents the result.
// ----------------------------------------------------------------------------
module wspp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     func_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wspp_pkg::cmd_t cmd_o,
  input  wspp_pkg::sts_t sts_i
);
  import wspp_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_TARGET: state_d = ST_TARGET;
            FUNC_SAMPLE: state_d = ST_SAMPLE;
            FUNC_TICK:   state_d = ST_TICK;
            default:     state_d = ST_OUT;
          endcase
        end
      end
      ST_TARGET: state_d = ST_OUT;
      ST_SAMPLE: state_d = ST_SDIV;
      ST_SDIV:   if (sts_i.div_done) state_d = ST_SFIN;
      ST_SFIN:   state_d = ST_OUT;
      ST_TICK:   state_d = sts_i.tick_active ? ST_DDIV : ST_TFIN;
      ST_DDIV:   if (sts_i.div_done) state_d = ST_P;
      ST_P:      state_d = ST_I;
      ST_I:      state_d = ST_D;
      ST_D:      state_d = ST_TFIN;
      ST_TFIN:   state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_TARGET: cmd_o.do_target = 1'b1;
      ST_SAMPLE: begin
        cmd_o.do_sample  = 1'b1;
        cmd_o.sdiv_start = 1'b1;
      end
      ST_SFIN:   cmd_o.do_sfin = 1'b1;
      ST_TICK:   cmd_o.ddiv_start = sts_i.tick_active;
      ST_P:      cmd_o.do_p = 1'b1;
      ST_I:      cmd_o.do_i = 1'b1;
      ST_D:      cmd_o.do_d = 1'b1;
      ST_TFIN:   cmd_o.do_tfin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/wspp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspp_dp
// Datapath: configuration, histories, speed estimate and incremental PID.
// ----------------------------------------------------------------------------
module wspp_dp #(
  parameter int unsigned HISTORY_DEPTH = 4,
  parameter int unsigned PWM_MAX = 15000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_accept_i,
  input  logic [11:0]           angle_raw_i,
  input  logic [31:0]           time_ms_i,
  input  logic signed [23:0]    target_speed_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  wspp_pkg::cmd_t        cmd_i,
  output wspp_pkg::sts_t        sts_o,
  output logic [13:0]           pwm_duty_o,
  output logic                  pin_a_o,
  output logic                  pin_b_o,
  output logic [1:0]            direction_o,
  output logic [22:0]           measured_speed_o
);
  import wspp_pkg::*;

  localparam int unsigned N = HISTORY_DEPTH;
  localparam logic [47:0] PwmLimit = 48'(PWM_MAX) << 16;

  logic [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic        side_q, enable_q;
  logic [11:0] angle_q;
  logic [31:0] time_q;
  logic signed [23:0] tgt_q;

  logic [8:0]  last_angle_q;
  logic [31:0] last_time_q;
  logic [22:0] spd_q [N];
  logic signed [24:0] err_q [N];
  logic [31:0] tim_q [N];
  logic signed [31:0] integ_q;
  logic [31:0] acc_q;
  logic [22:0] tmag_q;
  logic        pin_a_q, pin_b_q;
  logic [1:0]  dir_q;
  logic [13:0] duty_q;

  // Work registers
  logic [8:0]  deg_q;
  logic signed [25:0] errp_q;
  logic signed [31:0] derr_q;
  logic        dneg_q;
  logic signed [49:0] sum_q;

  // Divider sharing
  logic        div_start, div_done;
  logic [63:0] div_num, div_den, div_quo;

  // Sample arithmetic
  logic [20:0] ang_mul;
  logic [8:0]  deg;
  logic [31:0] dt_s;
  logic [8:0]  dang;
  logic [25:0] sum3;
  logic [52:0] mean_mul;
  logic [25:0] mean;
  logic [31:0] dt_t;
  logic signed [25:0] derr_raw;
  logic [25:0] derr_mag;
  logic [22:0] spd_new, spd_prev, spd_diff;
  logic signed [33:0] integ_w;
  logic signed [31:0] integ_sat;
  logic signed [49:0] sum_base;
  logic signed [49:0] sum_next;
  logic signed [16:0] gain_mul;
  logic signed [31:0] opnd;
  logic [23:0] tmag_abs;

  assign ang_mul = 21'(angle_q) * 21'd360 + 21'd2048;
  assign deg     = ang_mul[20:12];
  assign dt_s    = time_q - last_time_q;
  assign dang    = (last_angle_q > deg) ? last_angle_q - deg : deg - last_angle_q;
  assign sum3    = 26'(spd_q[N-1]) + 26'(spd_q[N-2]) + 26'(spd_q[N-3]);
  assign dt_t    = tim_q[N-1] - tim_q[N-2];
  assign derr_raw = 26'(err_q[N-1]) - 26'(err_q[N-2]);
  assign derr_mag = derr_raw[25] ? 26'(-derr_raw) : 26'(derr_raw);

  // Divide the speed sum by three with a reciprocal multiply
  assign mean_mul = 53'(sum3) * 53'd44739243;
  assign mean     = mean_mul[52:27];

  // Share one divider between speed and derivative
  always_comb begin
    div_start = cmd_i.sdiv_start | cmd_i.ddiv_start;
    div_num   = 64'(derr_mag);
    div_den   = (dt_t == '0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(dt_t);
    if (cmd_i.sdiv_start) begin
      div_num = 64'(dang) * 64'd128000;
      div_den = 64'(dt_s) * 64'd3;
    end
  end

  wspp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign sts_o.div_done    = div_done;
  assign sts_o.tick_active = (tmag_q != '0) && enable_q;

  // Filter the new speed
  always_comb begin
    spd_new = (dt_s > 32'd1 && div_quo >= 64'(SpeedMinQ8)) ? div_quo[22:0] : '0;
    spd_prev = spd_q[N-1];
    spd_diff = (spd_new > spd_prev) ? spd_new - spd_prev : spd_prev - spd_new;
    if (spd_new > 23'(SpeedTinyQ8) && spd_diff > 23'(SpeedJumpQ8)) begin
      spd_new = spd_prev;
    end
  end

  // Integral and product terms
  assign integ_w = 34'(integ_q) + 34'(errp_q);
  always_comb begin
    if (integ_w > 34'sh7FFF_FFFF) integ_sat = 32'sh8000_0000 - 32'sd1;
    else if (integ_w < -34'sh8000_0000) integ_sat = 32'sh8000_0000;
    else integ_sat = 32'(integ_w);
  end

  // Accumulate one gain product per step, starting from the PWM accumulator
  always_comb begin
    sum_base = sum_q;
    gain_mul = 17'({1'b0, gain_p_q});
    opnd     = 32'(errp_q);
    if (cmd_i.do_p) begin
      sum_base = 50'(acc_q);
    end
    if (cmd_i.do_i) begin
      gain_mul = 17'({1'b0, gain_i_q});
      opnd     = integ_sat;
    end else if (cmd_i.do_d) begin
      gain_mul = 17'({1'b0, gain_d_q});
      opnd     = derr_q;
    end
    sum_next = sum_base + 50'(gain_mul * 49'(opnd));
  end

  assign tmag_abs = tgt_q[23] ? 24'(-tgt_q) : 24'(tgt_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 16'd10240;
      gain_i_q <= '0;
      gain_d_q <= '0;
      side_q   <= 1'b0;
      enable_q <= 1'b1;
      last_angle_q <= '0;
      last_time_q  <= '0;
      for (int k = 0; k < N; k++) begin
        spd_q[k] <= '0;
        err_q[k] <= '0;
        tim_q[k] <= '0;
      end
      integ_q <= '0;
      acc_q   <= '0;
      tmag_q  <= '0;
      pin_a_q <= 1'b0;
      pin_b_q <= 1'b0;
      dir_q   <= '0;
      duty_q  <= '0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_GAIN_P: gain_p_q <= cfg_data_i[15:0];
          REG_GAIN_I: gain_i_q <= cfg_data_i[15:0];
          REG_GAIN_D: gain_d_q <= cfg_data_i[15:0];
          REG_SIDE:   side_q   <= cfg_data_i[0];
          REG_ENABLE: enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // Set target
      if (cmd_i.do_target) begin
        tmag_q <= (tmag_abs > 24'(SpeedLimit)) ? 23'(SpeedLimit) : tmag_abs[22:0];
        if (tgt_q == '0) begin
          pin_a_q <= 1'b0;
          pin_b_q <= 1'b0;
          dir_q   <= 2'd0;
          integ_q <= '0;
          duty_q  <= '0;
          last_angle_q <= '0;
          last_time_q  <= '0;
          for (int k = 0; k < N; k++) begin
            spd_q[k] <= '0;
            err_q[k] <= '0;
            tim_q[k] <= '0;
          end
        end else if ((!tgt_q[23]) == (!side_q)) begin
          pin_a_q <= 1'b0;
          pin_b_q <= 1'b1;
          dir_q   <= 2'd2;
        end else begin
          pin_a_q <= 1'b1;
          pin_b_q <= 1'b0;
          dir_q   <= 2'd1;
        end
      end
      // Shift in the new sample
      if (cmd_i.do_sfin) begin
        for (int k = 0; k < N - 1; k++) begin
          spd_q[k] <= spd_q[k+1];
          err_q[k] <= err_q[k+1];
          tim_q[k] <= tim_q[k+1];
        end
        spd_q[N-1] <= spd_new;
        tim_q[N-1] <= time_q;
        err_q[N-1] <= 25'(tmag_q) - 25'(spd_new);
        last_angle_q <= deg_q;
        last_time_q  <= time_q;
      end
      if (cmd_i.do_i) integ_q <= integ_sat;
      // Close the tick
      if (cmd_i.do_tfin && enable_q) begin
        if (tmag_q == '0) begin
          acc_q  <= '0;
          duty_q <= '0;
        end else if (sum_q < 0) begin
          acc_q  <= '0;
          duty_q <= '0;
        end else if (sum_q[48:0] > 49'(PwmLimit)) begin
          acc_q  <= 32'(PwmLimit);
          duty_q <= 14'(PWM_MAX);
        end else begin
          acc_q  <= sum_q[31:0];
          duty_q <= sum_q[29:16];
        end
      end
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      angle_q <= angle_raw_i;
      time_q  <= time_ms_i;
      tgt_q   <= target_speed_i;
    end
    if (cmd_i.do_sample) deg_q <= deg;
    if (cmd_i.ddiv_start) begin
      errp_q <= 26'(tmag_q) - mean;
      dneg_q <= derr_raw[25];
    end
    if (cmd_i.do_p) begin
      derr_q <= dneg_q ? -32'(div_quo[31:0]) : 32'(div_quo[31:0]);
    end
    if (cmd_i.do_p || cmd_i.do_i || cmd_i.do_d) begin
      sum_q <= sum_next;
    end
  end

  assign pwm_duty_o       = duty_q;
  assign pin_a_o          = pin_a_q;
  assign pin_b_o          = pin_b_q;
  assign direction_o      = dir_q;
  assign measured_speed_o = spd_q[N-1];
endmodule
